>>> design/rhc_pkg.sv
// rhc_pkg: shared types, codes and defaults for the handle cache.
// Used by rhc_cell and refcounted_handle_cache; depends on nothing.
`default_nettype none

package rhc_pkg;

    localparam int DEF_HANDLES   = 128;
    localparam int DEF_SLOTS     = 16;
    localparam int DEF_KEY_BITS  = 16;
    localparam int DEF_TIME_BITS = 32;

    // handle bitmap is searched this many handles per cycle
    localparam int CHUNK      = 16;
    localparam int CHUNK_W    = 4;
    localparam int USER_BITS  = 8;
    localparam logic [USER_BITS-1:0] USER_MAX = 8'hFF;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_OPEN   = 3'd1;
    localparam logic [2:0] ST_NO_HANDLE  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

    localparam logic OP_ATTACH = 1'b0;
    localparam logic OP_DETACH = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSTALL,
        CMD_ATTACH,
        CMD_DETACH
    } cell_cmd_t;

    typedef struct packed {
        logic used;
        logic take;   // this slot beats the incoming eviction candidate
    } cell_stat_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] name_id;
        logic [9:0]  handle_in;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  handle_out;
        logic [3:0]  slot;
        logic        reused;
        logic        evicted;
        logic [15:0] evicted_name;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/rhc_cell.sv
// rhc_cell: one object slot (valid, key, user count, idle stamp) and its
// link of the eviction candidate chain. Depends on rhc_pkg.
`default_nettype none

module rhc_cell #(
    parameter int KEY_BITS  = rhc_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS = rhc_pkg::DEF_TIME_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rhc_pkg::cell_cmd_t    cmd,
    input  wire logic [KEY_BITS-1:0]   key_in,
    input  wire logic [TIME_BITS-1:0]  time_in,
    input  wire logic                  best_valid_in,
    input  wire logic [TIME_BITS-1:0]  best_idle_in,
    output rhc_pkg::cell_stat_t        stat,
    output logic [KEY_BITS-1:0]        key_out,
    output logic [TIME_BITS-1:0]       idle_out
);
    import rhc_pkg::*;

    logic                  used_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [USER_BITS-1:0]  users_reg;
    logic [TIME_BITS-1:0]  idle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (cmd == CMD_INSTALL)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_INSTALL:
            begin
                key_reg   <= key_in;
                users_reg <= USER_BITS'(1);
                idle_reg  <= '0;
            end
            CMD_ATTACH:
            begin
                if (users_reg != USER_MAX)
                begin
                    users_reg <= users_reg + USER_BITS'(1);
                end
                idle_reg <= '0;
            end
            CMD_DETACH:
            begin
                if (users_reg != '0)
                begin
                    users_reg <= users_reg - USER_BITS'(1);
                    if (users_reg == USER_BITS'(1))
                    begin
                        idle_reg <= time_in;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // strict compare keeps the lower slot on equal idle times
    assign stat.used = used_reg;
    assign stat.take = used_reg && (users_reg == '0) &&
                       (!best_valid_in || (idle_reg < best_idle_in));
    assign key_out   = key_reg;
    assign idle_out  = idle_reg;

endmodule

`default_nettype wire

>>> design/refcounted_handle_cache.sv
// refcounted_handle_cache: top level with sequencer, handle bitmap, handle
// to slot memory and the row of rhc_cell slots. Depends on rhc_pkg, rhc_cell.
// One request is in work at a time. A detach goes from S_IDLE through S_DREAD
// and S_DAPPLY to S_DONE; a failed attach while closed or a bad handle goes
// straight from S_IDLE to S_DONE. An attach walks the slot row and the handle
// bitmap (16 handles a cycle) in parallel in S_SCAN, then S_APPLY and S_DONE.
// The result sits in an output register, so a new request is taken while the
// previous result still waits downstream.
`default_nettype none

module refcounted_handle_cache #(
    parameter int HANDLES   = rhc_pkg::DEF_HANDLES,
    parameter int SLOTS     = rhc_pkg::DEF_SLOTS,
    parameter int KEY_BITS  = rhc_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS = rhc_pkg::DEF_TIME_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire rhc_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rhc_pkg::out_item_t      out_item
);
    import rhc_pkg::*;

    localparam int HW       = $clog2(HANDLES);
    localparam int SW       = $clog2(SLOTS);
    localparam int NCHUNK   = (HANDLES + CHUNK - 1) / CHUNK;
    localparam int PADW     = NCHUNK * CHUNK;
    localparam int SCAN_LEN = (SLOTS > NCHUNK) ? SLOTS : NCHUNK;
    localparam int CW       = $clog2(SCAN_LEN) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DREAD,
        S_DAPPLY,
        S_DONE
    } state_t;

    function automatic out_item_t status_only(logic [2:0] st);
        out_item_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    state_t                 state_reg;
    logic                   open_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HW-1:0]          handle_reg;
    logic [TIME_BITS-1:0]   time_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   best_valid_reg;
    logic [TIME_BITS-1:0]   best_idle_reg;
    logic [SW-1:0]          best_idx_reg;
    logic [KEY_BITS-1:0]    best_key_reg;
    logic                   free_found_reg;
    logic [HW-1:0]          free_handle_reg;
    logic [HANDLES-1:0]     handle_used_reg;
    out_item_t              res_reg;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;

    logic [SW-1:0]          slot_mem [HANDLES];
    logic [SW-1:0]          mem_rd_reg;

    cell_cmd_t              cell_cmd  [SLOTS];
    cell_stat_t             cell_stat [SLOTS];
    logic [KEY_BITS-1:0]    cell_key  [SLOTS];
    logic [TIME_BITS-1:0]   cell_idle [SLOTS];

    logic [SW-1:0]          cur_idx;
    logic                   slot_scan;
    logic                   chunk_scan;
    logic [PADW-1:0]        free_pad;
    logic [CHUNK-1:0]       chunk_bits;
    logic                   chunk_any;
    logic [CHUNK_W-1:0]     chunk_pos;
    logic [CW+CHUNK_W-1:0]  chunk_handle;
    logic                   hit_any;
    logic [SW-1:0]          hit_idx;
    logic                   empty_any;
    logic [SW-1:0]          empty_idx;
    logic                   att_ok;
    cell_cmd_t              att_cmd;
    logic [SW-1:0]          att_slot;
    logic [SW-1:0]          det_slot;
    logic                   handle_ok;
    logic [TIME_BITS-1:0]   stamp;
    logic                   out_free;

    // slot row
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rhc_cell #(
            .KEY_BITS  (KEY_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cell_cmd[g]),
            .key_in        (key_reg),
            .time_in       (stamp),
            .best_valid_in (best_valid_reg),
            .best_idle_in  (best_idle_reg),
            .stat          (cell_stat[g]),
            .key_out       (cell_key[g]),
            .idle_out      (cell_idle[g])
        );
    end

    assign stamp     = (time_reg == '0) ? TIME_BITS'(1) : time_reg;
    assign cur_idx   = SW'(cnt_reg);
    assign slot_scan  = (cnt_reg < CW'(SLOTS));
    assign chunk_scan = (cnt_reg < CW'(NCHUNK));
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign handle_ok = ({1'b0, in_item.handle_in} < 11'(HANDLES)) &&
                       handle_used_reg[HW'(in_item.handle_in)];

    always_comb
    begin
        free_pad = '0;
        free_pad[HANDLES-1:0] = ~handle_used_reg;
        chunk_bits = '0;
        if (chunk_scan)
        begin
            chunk_bits = free_pad[cnt_reg * CHUNK +: CHUNK];
        end
        chunk_any = |chunk_bits;
        chunk_pos = '0;
        for (int b = CHUNK - 1; b >= 0; b--)
        begin
            if (chunk_bits[b])
            begin
                chunk_pos = CHUNK_W'(b);
            end
        end
        chunk_handle = {cnt_reg, chunk_pos};
    end

    always_comb
    begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        empty_any = 1'b0;
        empty_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (cell_stat[i].used && (cell_key[i] == key_reg))
            begin
                hit_any = 1'b1;
                hit_idx = SW'(i);
            end
            if (!cell_stat[i].used)
            begin
                empty_any = 1'b1;
                empty_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        att_ok   = 1'b1;
        att_cmd  = CMD_INSTALL;
        att_slot = best_idx_reg;
        priority if (!free_found_reg)
        begin
            att_ok = 1'b0;
        end
        else if (hit_any)
        begin
            att_cmd  = CMD_ATTACH;
            att_slot = hit_idx;
        end
        else if (empty_any)
        begin
            att_slot = empty_idx;
        end
        else if (!best_valid_reg)
        begin
            att_ok = 1'b0;
        end
        det_slot = (32'(mem_rd_reg) >= SLOTS) ? '0 : mem_rd_reg;
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            cell_cmd[i] = CMD_NONE;
            if ((state_reg == S_APPLY) && att_ok && (att_slot == SW'(i)))
            begin
                cell_cmd[i] = att_cmd;
            end
            if ((state_reg == S_DAPPLY) && (det_slot == SW'(i)))
            begin
                cell_cmd[i] = CMD_DETACH;
            end
        end
    end

    // handle to slot table; read with the latched handle
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_APPLY) && att_ok)
        begin
            slot_mem[free_handle_reg] <= att_slot;
        end
        mem_rd_reg <= slot_mem[handle_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            open_reg        <= 1'b0;
            handle_used_reg <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            best_valid_reg  <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                open_reg <= cfg_data;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        key_reg        <= KEY_BITS'(in_item.name_id);
                        handle_reg     <= HW'(in_item.handle_in);
                        time_reg       <= TIME_BITS'(in_item.now_time);
                        cnt_reg        <= '0;
                        best_valid_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (in_item.operation == OP_DETACH)
                        begin
                            if (handle_ok)
                            begin
                                res_reg   <= '0;
                                state_reg <= S_DREAD;
                            end
                            else
                            begin
                                res_reg   <= status_only(ST_BAD_HANDLE);
                                state_reg <= S_DONE;
                            end
                        end
                        else if (!open_reg)
                        begin
                            res_reg   <= status_only(ST_NOT_OPEN);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            res_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // eviction candidate passes from cell to cell
                    if (slot_scan && cell_stat[cur_idx].take)
                    begin
                        best_valid_reg <= 1'b1;
                        best_idle_reg  <= cell_idle[cur_idx];
                        best_idx_reg   <= cur_idx;
                        best_key_reg   <= cell_key[cur_idx];
                    end
                    if (!free_found_reg && chunk_any)
                    begin
                        free_found_reg  <= 1'b1;
                        free_handle_reg <= HW'(chunk_handle);
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(SCAN_LEN - 1))
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (att_ok)
                    begin
                        handle_used_reg[free_handle_reg] <= 1'b1;
                        res_reg.status     <= ST_OK;
                        res_reg.handle_out <= 7'(free_handle_reg);
                        res_reg.slot       <= 4'(att_slot);
                        res_reg.reused     <= hit_any;
                        res_reg.evicted    <= !hit_any && !empty_any;
                        res_reg.evicted_name <= (!hit_any && !empty_any) ?
                                                16'(best_key_reg) : 16'd0;
                    end
                    else
                    begin
                        res_reg.status <= free_found_reg ? ST_FULL : ST_NO_HANDLE;
                    end
                    state_reg <= S_DONE;
                end
                S_DREAD:
                begin
                    state_reg <= S_DAPPLY;
                end
                S_DAPPLY:
                begin
                    handle_used_reg[handle_reg] <= 1'b0;
                    res_reg.status <= ST_OK;
                    res_reg.slot   <= 4'(det_slot);
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_item_reg  <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire
